// ===== rtl/shader_hwreg_field_access_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hardware-register field access block
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHADER_HWREG_FIELD_ACCESS_DEFINES_SVH
`define SHADER_HWREG_FIELD_ACCESS_DEFINES_SVH

// Condition must never hold outside reset.
`define SHFA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SHFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SHFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/shfa_pkg.sv =====
// ----------------------------------------------------------------------------
// shfa_pkg
// Types, codes and register inventory tables for the field access block.
// ----------------------------------------------------------------------------
`default_nettype none
package shfa_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNSUPP   = 2'd1,
    ST_READONLY = 2'd2,
    ST_PRIV     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_MODE    = 3'd1,
    K_STATUS  = 3'd2,
    K_ALLOC_A = 3'd3,
    K_ALLOC_B = 3'd4,
    K_SCHED   = 3'd5,
    K_IBSTS   = 3'd6,
    K_IBSTS2  = 3'd7
  } kind_t;

  // What the back end does with a queued entry.
  typedef enum logic [2:0] {
    ACT_STATUS      = 3'd0,  // reply with status only, data zero
    ACT_READ_RAW    = 3'd1,  // extract field from word carried in the entry
    ACT_READ_MODE   = 3'd2,
    ACT_READ_SCHED  = 3'd3,
    ACT_WRITE_MODE  = 3'd4,
    ACT_WRITE_SCHED = 3'd5
  } act_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] TABLE_NONE = 3'd7;

  typedef struct packed {
    act_t        act;
    status_t     status;
    logic [4:0]  offset;
    logic [31:0] mask;
    logic [31:0] word;   // raw word for reads, write data for writes
  } entry_t;

  localparam logic [63:0] PRESENT_IDS [8] = '{
    64'h000FFFFE, 64'h01FFFFFE, 64'h1FFFFFFE, 64'h3FBFE7EE,
    64'h3FBFE3EE, 64'h71BF9C76, 64'h615BFDCF6, 64'h0};
  localparam logic [63:0] USER_IDS [8] = '{
    64'hC00A, 64'hC00A, 64'hC00A, 64'hC00A,
    64'h400A, 64'h40002, 64'h4044002, 64'h0};
  localparam logic [63:0] PRIV_IDS [8] = '{
    64'hF0000, 64'hF0000, 64'hF0000, 64'hF0000,
    64'h30000, 64'h3A0010, 64'h6003A0010, 64'h0};

  function automatic kind_t kind_of(input logic [2:0] set, input logic [5:0] id);
    kind_t k;
    k = K_NONE;
    if (id == 6'd1) k = K_MODE;
    else if (id == 6'd2) k = K_STATUS;
    else if (id == 6'd5) begin
      if (set == 3'd0 || set == 3'd2 || set == 3'd3) k = K_ALLOC_A;
      else if (set == 3'd1) k = K_ALLOC_B;
    end else if (set == 3'd6) begin
      if (id == 6'd7) k = K_IBSTS;
      else if (id == 6'd26) k = K_SCHED;
      else if (id == 6'd28) k = K_IBSTS2;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/shfa_front.sv =====
// ----------------------------------------------------------------------------
// shfa_front
// Decodes the operand, looks up the inventory and builds raw words.
// ----------------------------------------------------------------------------
`default_nettype none
module shfa_front import shfa_pkg::*; (
  input  wire logic [2:0]  table_set,
  input  wire logic        op,
  input  wire logic [15:0] hwreg_operand,
  input  wire logic [31:0] write_data,
  input  wire logic [31:0] status_word,
  input  wire logic [9:0]  vector_reg_base,
  input  wire logic [9:0]  vector_reg_count,
  input  wire logic [9:0]  scalar_reg_base,
  input  wire logic [8:0]  scalar_reg_count,
  input  wire logic [36:0] wait_counts,
  input  wire logic [7:0]  group_size,
  input  wire logic [3:0]  group_rank,
  output entry_t           entry
);

  logic [5:0]  id;
  logic [4:0]  offset;
  logic [5:0]  size;
  logic [5:0]  end_bit;
  logic [31:0] mask;
  kind_t       kind;
  logic        present, user, priv;
  logic [9:0]  vc_m1;
  logic [8:0]  sc_m1;
  logic [5:0]  vblk;
  logic [3:0]  sblk_a, sblk_b;
  logic [7:0]  tensor;
  logic [1:0]  tensor_sat;
  logic [31:0] raw;

  assign id     = hwreg_operand[5:0];
  assign offset = hwreg_operand[10:6];

  always_comb begin
    size = {1'b0, hwreg_operand[15:11]} + 6'd1;
    if ({1'b0, offset} + size > 6'd32) size = 6'd32 - {1'b0, offset};
  end

  assign end_bit = {1'b0, offset} + size;
  assign mask    = 32'hFFFF_FFFF >> (6'd32 - size);
  assign kind    = kind_of(table_set, id);
  assign present = PRESENT_IDS[table_set][id];
  assign user    = USER_IDS[table_set][id];
  assign priv    = PRIV_IDS[table_set][id];

  // zero count gives zero blocks-minus-one
  assign vc_m1      = (vector_reg_count == 10'd0) ? 10'd0 : vector_reg_count - 10'd1;
  assign sc_m1      = (scalar_reg_count == 9'd0) ? 9'd0 : scalar_reg_count - 9'd1;
  assign vblk       = vc_m1[7:2];
  assign sblk_a     = sc_m1[6:3];
  assign sblk_b     = sc_m1[7:4];
  assign tensor     = wait_counts[36:29];
  assign tensor_sat = (tensor > 8'd3) ? 2'd3 : tensor[1:0];

  always_comb begin
    raw = '0;
    case (kind)
      K_STATUS:  raw = status_word;
      K_ALLOC_A: begin
        raw[5:0]   = vector_reg_base[7:2];
        raw[13:8]  = vblk;
        raw[21:16] = scalar_reg_base[8:3];
        raw[27:24] = sblk_a;
      end
      K_ALLOC_B: begin
        raw[5:0]   = vector_reg_base[7:2];
        raw[11:6]  = vblk;
        raw[23:18] = scalar_reg_base[8:3];
        raw[27:24] = sblk_b;
      end
      K_IBSTS: begin
        raw[8:3]   = wait_counts[5:0];
        raw[14:9]  = wait_counts[11:6];
        raw[29:24] = wait_counts[17:12];
      end
      K_IBSTS2: begin
        raw[4:0]   = wait_counts[22:18];
        raw[6]     = (group_size > 8'd1);
        raw[17:12] = wait_counts[28:23];
        raw[19:18] = tensor_sat;
        raw[24:21] = group_rank;
        raw[29:28] = 2'd3;
      end
      default: raw = '0;
    endcase
  end

  always_comb begin
    entry.act    = ACT_STATUS;
    entry.status = ST_OK;
    entry.offset = offset;
    entry.mask   = mask;
    entry.word   = raw;
    if (!present) begin
      entry.status = ST_UNSUPP;
    end else if (op == OP_READ) begin
      if (kind == K_NONE) entry.status = ST_UNSUPP;
      else if (kind == K_ALLOC_B && offset < 5'd18 && end_bit > 6'd12)
        entry.status = ST_UNSUPP;
      else if (kind == K_MODE) entry.act = ACT_READ_MODE;
      else if (kind == K_SCHED) entry.act = ACT_READ_SCHED;
      else entry.act = ACT_READ_RAW;
    end else if (priv) begin
      entry.status = ST_PRIV;
    end else if (!user) begin
      entry.status = ST_READONLY;
    end else begin
      entry.word = write_data;
      if (kind == K_MODE) entry.act = ACT_WRITE_MODE;
      else if (kind == K_SCHED) entry.act = ACT_WRITE_SCHED;
      else entry.status = ST_UNSUPP;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/shfa_queue.sv =====
// ----------------------------------------------------------------------------
// shfa_queue
// Two-entry queue between decode and execute.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shader_hwreg_field_access_defines.svh"
module shfa_queue import shfa_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  output logic        not_empty,
  input  wire logic   pop,
  output entry_t      head
);

  entry_t     slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `SHFA_ASSERT_NEVER(a_no_overfill, count_r > 2'd2, "queue count above depth")
  `SHFA_ASSERT_NEVER(a_push_full, push && full, "push into full queue")
  `SHFA_ASSERT_NEVER(a_pop_empty, pop && !not_empty, "pop from empty queue")
  `SHFA_ASSERT_IMPL(a_ptr_track, count_r == 2'd0 || count_r == 2'd2,
                    wr_ptr_r == rd_ptr_r, "pointers disagree with count")

endmodule
`default_nettype wire

// ===== rtl/shfa_back.sv =====
// ----------------------------------------------------------------------------
// shfa_back
// Executes queued accesses against the mode words; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module shfa_back import shfa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire entry_t      head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic [1:0]       out_access_status
);

  logic [31:0] mode_word_r, mode_word_nxt;
  logic [31:0] sched_word_r, sched_word_nxt;
  logic        out_valid_r;
  logic [31:0] data_r, data_nxt;
  logic [1:0]  status_r;
  logic [31:0] src, merged, field_mask;

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    src = '0;
    case (head.act) inside
      ACT_READ_RAW:                    src = head.word;
      ACT_READ_MODE, ACT_WRITE_MODE:   src = mode_word_r;
      ACT_READ_SCHED, ACT_WRITE_SCHED: src = sched_word_r;
      default:                         src = '0;
    endcase
  end

  assign field_mask = head.mask << head.offset;
  assign merged     = (src & ~field_mask) | ((head.word & head.mask) << head.offset);

  always_comb begin
    mode_word_nxt  = mode_word_r;
    sched_word_nxt = sched_word_r;
    data_nxt       = '0;
    case (head.act) inside
      ACT_READ_RAW, ACT_READ_MODE, ACT_READ_SCHED:
        data_nxt = (src >> head.offset) & head.mask;
      ACT_WRITE_MODE:  mode_word_nxt  = merged;
      ACT_WRITE_SCHED: sched_word_nxt = merged;
      default:         data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r   <= data_nxt;
      status_r <= head.status;
    end
    if (!rst_n) begin
      mode_word_r  <= '0;
      sched_word_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        mode_word_r  <= mode_word_nxt;
        sched_word_r <= sched_word_nxt;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = data_r;
  assign out_access_status = status_r;

endmodule
`default_nettype wire

// ===== rtl/shader_hwreg_field_access.sv =====
// ----------------------------------------------------------------------------
// shader_hwreg_field_access
// Top level: get/set hardware-register bit-field access unit.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out, in order. Throughput is one access
// per cycle while out_ready holds; the decode result lands in a two-entry queue,
// then the execute stage updates the mode words and loads the result register.
// Input and output stall independently. table_set sits at byte address 0 of
// the APB port; write it only while no access is in flight.
`default_nettype none
module shader_hwreg_field_access import shfa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [15:0] in_hwreg_operand,
  input  wire logic [31:0] in_write_data,
  input  wire logic [31:0] in_status_word,
  input  wire logic [9:0]  in_vector_reg_base,
  input  wire logic [9:0]  in_vector_reg_count,
  input  wire logic [9:0]  in_scalar_reg_base,
  input  wire logic [8:0]  in_scalar_reg_count,
  input  wire logic [36:0] in_wait_counts,
  input  wire logic [7:0]  in_group_size,
  input  wire logic [3:0]  in_group_rank,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic [1:0]       out_access_status
);

  logic [2:0] table_set_r;
  entry_t     dec_entry, head;
  logic       q_full, q_valid, pop;

  // APB: single register at word 0; upper word slot reads zero
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {29'd0, table_set_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_set_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      table_set_r <= cfg_pwdata[2:0];
    end
  end

  assign in_ready = !q_full;

  shfa_front u_front (
    .table_set        (table_set_r),
    .op               (in_op),
    .hwreg_operand    (in_hwreg_operand),
    .write_data       (in_write_data),
    .status_word      (in_status_word),
    .vector_reg_base  (in_vector_reg_base),
    .vector_reg_count (in_vector_reg_count),
    .scalar_reg_base  (in_scalar_reg_base),
    .scalar_reg_count (in_scalar_reg_count),
    .wait_counts      (in_wait_counts),
    .group_size       (in_group_size),
    .group_rank       (in_group_rank),
    .entry            (dec_entry)
  );

  shfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && in_ready),
    .push_entry (dec_entry),
    .full       (q_full),
    .not_empty  (q_valid),
    .pop        (pop),
    .head       (head)
  );

  shfa_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_access_status (out_access_status)
  );

endmodule
`default_nettype wire
